@@ rtl/carp_pkg.sv @@
// ----------------------------------------------------------------------------
// carp_pkg - shared types, constants and tables of the chord arpeggiator
// Scale and voicing tables, register and order codes, the note fold and the
// DAC code table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package carp_pkg;

	localparam int NOTE_TOP  = 60;
	localparam int OCT_SEMIS = 12;
	localparam int DAC_MAX   = 4095;

	localparam int SCALE_LAST = 6;
	localparam int VOICE_LAST = 14;
	localparam int DIV_LAST   = 4;

	// Register indexes on the write port
	typedef enum logic [2:0] {
		REG_TONIC   = 3'd0,
		REG_SCALE   = 3'd1,
		REG_VOICING = 3'd2,
		REG_ORDER   = 3'd3,
		REG_OCTAVE  = 3'd4,
		REG_DIVIDE  = 3'd5
	} cfg_reg_t;

	// Traversal orders; every other code plays as up
	localparam logic [2:0] ORD_UP         = 3'd0;
	localparam logic [2:0] ORD_DOWN       = 3'd1;
	localparam logic [2:0] ORD_UPDOWN_INC = 3'd2;
	localparam logic [2:0] ORD_UPDOWN_EXC = 3'd3;

	typedef logic [3:0] scale_row_t [7];
	typedef scale_row_t scale_tab_t [7];

	localparam scale_tab_t SCALE_TAB = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10}
	};

	typedef logic [2:0] voice_len_tab_t [15];

	localparam voice_len_tab_t VOICE_LEN = '{
		3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd7, 3'd4,
		3'd3, 3'd3, 3'd6, 3'd2, 3'd3, 3'd3, 3'd3
	};

	// Voicing degrees split into scale index (degree-1 mod 7) and octave
	typedef logic [2:0] idx_row_t [7];
	typedef idx_row_t idx_tab_t [15];
	typedef logic [1:0] oct_row_t [7];
	typedef oct_row_t oct_tab_t [15];

	localparam idx_tab_t VOICE_IDX = '{
		'{3'd0, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd0},
		'{3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5},
		'{3'd0, 3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd4, 3'd1, 3'd2, 3'd6, 3'd3, 3'd0},
		'{3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd6, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd2, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0}
	};

	localparam oct_tab_t VOICE_OCT = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0},
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0}
	};

	// Fold a raw note down by octaves until it is at most NOTE_TOP.
	// Count the thresholds it passes, then take that many octaves off.
	function automatic logic [5:0] fold_note(input logic [7:0] raw);
		logic [2:0] k;
		logic [7:0] r;
		k = '0;
		for (int j = 0; j < 7; j++) begin
			if (raw > 8'(NOTE_TOP + OCT_SEMIS * j))
				k = k + 3'd1;
		end
		r = raw - 8'(k) * 8'(OCT_SEMIS);
		return r[5:0];
	endfunction

	// DAC code per semitone: round(semi*4096/60), saturated
	typedef logic [11:0] dac_tab_t [64];

	function automatic dac_tab_t build_dac_tab();
		dac_tab_t t;
		int code;
		for (int i = 0; i < 64; i++) begin
			code = (i * 2048 + 15) / 30;
			if (code > DAC_MAX)
				code = DAC_MAX;
			t[i] = 12'(code);
		end
		return t;
	endfunction

	localparam dac_tab_t DAC_TAB = build_dac_tab();

endpackage

@@ rtl/chord_arpeggiator_step.sv @@
// ----------------------------------------------------------------------------
// chord_arpeggiator_step - clock-divided chord arpeggiator step
// Divides incoming clock pulses, walks the chord notes in the selected order
// and reports step, semitone and DAC code for every tick word.
//
//   channel   dir   handshake           payload
//   in        in    in_valid/in_stall   pulse
//   out       out   out_valid/out_stall fire, step_index, semitone, dac_code
//   config    in    wr_en               wr_index, wr_data
//
// One word per cycle sustained while not stalled; a word lands in the input
// register at the edge that takes it and shows on the output from the result
// register. The path between them is the traversal step, the voicing/scale
// lookup, the octave fold and the DAC table. Reset clears registers, counters
// and both valid flags. A stall on the output holds the result register and
// the input register behind it; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chord_arpeggiator_step
	import carp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// tick words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        pulse,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fire,
	output logic [2:0]  step_index,
	output logic [5:0]  semitone,
	output logic [11:0] dac_code,
	// register writes
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [3:0]  wr_data
);

	// Configuration registers
	logic [3:0] tonic_q;
	logic [2:0] scale_q;
	logic [3:0] voicing_q;
	logic [2:0] order_q;
	logic [2:0] octave_q;
	logic [2:0] divide_q;

	// Arpeggiator state
	logic [3:0] pulse_cnt_q;
	logic [3:0] seq_pos_q;
	logic [2:0] step_q;

	// Input register
	logic valid_s1;
	logic pulse_s1;

	// Result register
	logic        out_valid_q;
	logic        fire_q;
	logic [2:0]  step_out_q;
	logic [5:0]  semi_q;
	logic [11:0] dac_q;

	logic advance;
	logic take;
	logic work;

	// Next-state and result values for the word in the input register
	logic        fire_nx;
	logic [3:0]  pulse_cnt_nx;
	logic [3:0]  seq_pos_nx;
	logic [2:0]  step_nx;
	logic [5:0]  semi_nx;
	logic [11:0] dac_nx;

	// The result register can load when it is empty or being emptied
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;
	assign work     = valid_s1 && advance;

	always_comb begin
		logic [2:0] div_sel;
		logic [4:0] cnt;
		logic [4:0] div;
		logic [3:0] voice;
		logic [2:0] scale;
		logic [2:0] n;
		logic [3:0] len;
		logic [3:0] p;
		logic [3:0] elem;
		logic [3:0] p_inc;
		logic [2:0] slot;
		logic [2:0] ix;
		logic [1:0] oc;
		logic [3:0] oct_sum;
		logic [7:0] raw;

		voice = (voicing_q > 4'(VOICE_LAST)) ? 4'(VOICE_LAST) : voicing_q;
		scale = (scale_q > 3'(SCALE_LAST)) ? 3'(SCALE_LAST) : scale_q;
		n     = VOICE_LEN[voice];

		// Traversal length for the chosen order
		case (order_q)
			ORD_UPDOWN_INC: len = {n, 1'b0} - 4'd1;
			ORD_UPDOWN_EXC: len = {n, 1'b0} - 4'd2;
			default:        len = {1'b0, n};
		endcase

		p = (seq_pos_q >= len) ? 4'd0 : seq_pos_q;

		// Chord index at this position
		case (order_q)
			ORD_DOWN:       elem = {1'b0, n} - 4'd1 - p;
			ORD_UPDOWN_INC: elem = (p < {1'b0, n}) ? p : {n, 1'b0} - 4'd1 - p;
			ORD_UPDOWN_EXC: elem = (p < {1'b0, n}) ? p : {n, 1'b0} - 4'd2 - p;
			default:        elem = p;
		endcase

		p_inc = p + 4'd1;
		if (p_inc >= len)
			p_inc = 4'd0;

		// Divide pulses; ratio codes above four saturate at a ratio of sixteen
		div_sel = (divide_q > 3'(DIV_LAST)) ? 3'(DIV_LAST) : divide_q;
		div     = 5'd1 << div_sel;
		cnt     = {1'b0, pulse_cnt_q} + 5'd1;

		fire_nx      = 1'b0;
		pulse_cnt_nx = pulse_cnt_q;
		seq_pos_nx   = seq_pos_q;
		step_nx      = step_q;
		if (pulse_s1) begin
			if (cnt >= div) begin
				fire_nx      = 1'b1;
				step_nx      = elem[2:0];
				seq_pos_nx   = p_inc;
				pulse_cnt_nx = 4'd0;
			end else begin
				pulse_cnt_nx = cnt[3:0];
			end
		end

		// Note of the step now sounding; a stale step plays the top chord note
		slot    = (step_nx >= n) ? n - 3'd1 : step_nx;
		ix      = VOICE_IDX[voice][slot];
		oc      = VOICE_OCT[voice][slot];
		oct_sum = {2'b00, oc} + {1'b0, octave_q};
		raw     = {4'b0000, SCALE_TAB[scale][ix]} + 8'(oct_sum) * 8'(OCT_SEMIS)
			+ {4'b0000, tonic_q};
		semi_nx = fold_note(raw);
		dac_nx  = DAC_TAB[semi_nx];
	end

	// Configuration registers and arpeggiator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tonic_q     <= '0;
			scale_q     <= '0;
			voicing_q   <= '0;
			order_q     <= '0;
			octave_q    <= '0;
			divide_q    <= '0;
			pulse_cnt_q <= '0;
			seq_pos_q   <= '0;
			step_q      <= '0;
		end else begin
			if (work) begin
				pulse_cnt_q <= pulse_cnt_nx;
				seq_pos_q   <= seq_pos_nx;
				step_q      <= step_nx;
			end
			// Any write to a known register restarts the traversal
			if (wr_en) begin
				unique case (wr_index)
					REG_TONIC: begin
						tonic_q   <= wr_data;
						seq_pos_q <= '0;
					end
					REG_SCALE: begin
						scale_q   <= wr_data[2:0];
						seq_pos_q <= '0;
					end
					REG_VOICING: begin
						voicing_q <= wr_data;
						seq_pos_q <= '0;
					end
					REG_ORDER: begin
						order_q   <= wr_data[2:0];
						seq_pos_q <= '0;
					end
					REG_OCTAVE: begin
						octave_q  <= wr_data[2:0];
						seq_pos_q <= '0;
					end
					REG_DIVIDE: begin
						divide_q  <= wr_data[2:0];
						seq_pos_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Input register: load on accept, drain into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= take;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			pulse_s1 <= pulse;
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			fire_q     <= fire_nx;
			step_out_q <= step_nx;
			semi_q     <= semi_nx;
			dac_q      <= dac_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign fire       = fire_q;
	assign step_index = step_out_q;
	assign semitone   = semi_q;
	assign dac_code   = dac_q;

	// Traversal position stays inside the longest traversal
	a_seq_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_pos_q <= 4'd12)
		else $error("sequence position beyond longest traversal");

	// Stepped-to chord index never exceeds the largest chord
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 3'd6)
		else $error("chord step beyond largest chord");

	// Reported note stays folded, and at the top of range its code is saturated
	a_semi_fold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (semi_q <= 6'(NOTE_TOP)) &&
			((semi_q != 6'(NOTE_TOP)) || (dac_q == 12'(DAC_MAX))))
		else $error("semitone out of range or top code not saturated");

	// A word waiting behind a stalled result is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && out_valid_q)
		else $error("word lost under output stall");

endmodule
